@@ rtl/double_ended_queue_with_reverse_assert.svh @@
// ----------------------------------------------------------------------------
// double_ended_queue_with_reverse_assert
// assertion macros shared by the deque checker
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_WITH_REVERSE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_WITH_REVERSE_ASSERT_SVH

// same-cycle implication
`define DQR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deque assertion failed");

// next-cycle implication
`define DQR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deque assertion failed");

`endif

@@ rtl/dqr_pkg.sv @@
// ----------------------------------------------------------------------------
// dqr_pkg
// shared types and constants of the bounded deque with reversal
// ----------------------------------------------------------------------------
package dqr_pkg;

	localparam int DEPTH_DEFAULT = 16;

	localparam int KIND_W  = 2;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;

	// slave side: tdata = value, tuser = kind
	localparam int S_TDATA_W = 32;
	localparam int S_TUSER_W = KIND_W;
	// master side: tdata = removed_value, count, zero fill; tuser = ok
	localparam int M_TDATA_W = 40;
	localparam int M_TUSER_W = 1;
	localparam int M_PAD_W   = M_TDATA_W - VALUE_W - COUNT_W;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH_FRONT = 2'd0,
		KIND_PUSH_BACK  = 2'd1,
		KIND_POP_FRONT  = 2'd2,
		KIND_REVERSE    = 2'd3
	} kind_t;

endpackage

@@ rtl/double_ended_queue_with_reverse.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_with_reverse
// bounded deque of 32-bit values in a ring buffer memory with a direction flag
// push, reverse and failed ops give their result in the cycle after accept
// a successful pop stalls input, reads memory into rd_data_q, then registers its result
// throughput: 1 beat per cycle for push and reverse while m_tready is high
// asynchronous active-low reset empties the queue and clears the direction flag
// ----------------------------------------------------------------------------
module double_ended_queue_with_reverse
	import dqr_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEPTH_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] value
	input  logic [S_TUSER_W-1:0] s_tuser,   // [1:0] kind
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] removed_value, [36:32] count, zero fill
	output logic [M_TUSER_W-1:0] m_tuser    // [0] ok
);

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	logic [VALUE_W-1:0] mem [QUEUE_DEPTH];

	logic [IDX_W-1:0]   front_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               rev_q;
	logic               pend_q;
	logic [VALUE_W-1:0] rd_data_q;
	logic               out_valid_q;
	logic               out_ok_q;
	logic [VALUE_W-1:0] out_val_q;
	logic [COUNT_W-1:0] out_cnt_q;

	kind_t            kind;
	logic             accept;
	logic             full;
	logic             empty;
	logic             is_push;
	logic             is_pop;
	logic             at_first;
	logic             do_push;
	logic             do_pop;
	logic [IDX_W-1:0] front_inc;
	logic [IDX_W-1:0] front_dec;
	logic [SUM_W-1:0] sum_tail;
	logic [SUM_W-1:0] sum_last;
	logic [IDX_W-1:0] tail_idx;
	logic [IDX_W-1:0] last_idx;
	logic [IDX_W-1:0] wr_addr;
	logic [IDX_W-1:0] rd_addr;
	logic [CNT_W-1:0] cnt_next;
	logic [IDX_W-1:0] front_next;

	assign kind     = kind_t'(s_tuser);
	assign s_tready = !pend_q && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign full     = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign is_push  = (kind == KIND_PUSH_FRONT) || (kind == KIND_PUSH_BACK);
	assign is_pop   = (kind == KIND_POP_FRONT);
	assign at_first = ((kind == KIND_PUSH_FRONT) == !rev_q);
	assign do_push  = accept && is_push && !full;
	assign do_pop   = accept && is_pop && !empty;

	always_comb begin
		front_inc = (front_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : front_q + 1'b1;
		front_dec = (front_q == '0) ? IDX_W'(QUEUE_DEPTH - 1) : front_q - 1'b1;

		sum_tail = SUM_W'(front_q) + SUM_W'(cnt_q);
		if (sum_tail >= SUM_W'(QUEUE_DEPTH)) begin
			sum_tail = sum_tail - SUM_W'(QUEUE_DEPTH);
		end
		tail_idx = sum_tail[IDX_W-1:0];

		sum_last = SUM_W'(front_q) + SUM_W'(cnt_q) - 1'b1;
		if (sum_last >= SUM_W'(QUEUE_DEPTH)) begin
			sum_last = sum_last - SUM_W'(QUEUE_DEPTH);
		end
		last_idx = sum_last[IDX_W-1:0];

		wr_addr = at_first ? front_dec : tail_idx;
		rd_addr = rev_q ? last_idx : front_q;

		front_next = front_q;
		cnt_next   = cnt_q;
		if (do_push) begin
			cnt_next = cnt_q + 1'b1;
			if (at_first) begin
				front_next = front_dec;
			end
		end else if (do_pop) begin
			cnt_next = cnt_q - 1'b1;
			if (!rev_q) begin
				front_next = front_inc;
			end
			if (cnt_q == CNT_W'(1)) begin
				front_next = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			cnt_q       <= '0;
			rev_q       <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			front_q <= front_next;
			cnt_q   <= cnt_next;
			if (accept && (kind == KIND_REVERSE)) begin
				rev_q <= !rev_q;
			end
			pend_q <= do_pop;
			if (pend_q || (accept && !do_pop)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_addr] <= s_tdata[VALUE_W-1:0];
		end
		if (do_pop) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q) begin
			out_ok_q  <= 1'b1;
			out_val_q <= rd_data_q;
			out_cnt_q <= COUNT_W'(cnt_q);
		end else if (accept && !do_pop) begin
			out_ok_q  <= do_push || (kind == KIND_REVERSE);
			out_val_q <= '0;
			out_cnt_q <= COUNT_W'(cnt_next);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, out_cnt_q, out_val_q};
	assign m_tuser  = out_ok_q;

endmodule

@@ rtl/dqr_checker.sv @@
// ----------------------------------------------------------------------------
// dqr_checker
// port-level checks of the deque, bound to the top level
// ----------------------------------------------------------------------------
`include "double_ended_queue_with_reverse_assert.svh"

module dqr_checker
	import dqr_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [S_TUSER_W-1:0] s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [M_TUSER_W-1:0] m_tuser
);

	logic                           s_beat;
	logic                           s_rev;
	logic                           s_pop;
	logic [VALUE_W-1:0]             m_removed;
	logic [M_TDATA_W+M_TUSER_W-1:0] m_beat_bits;

	assign s_beat      = s_tvalid && s_tready;
	assign s_rev       = s_beat && (s_tuser == KIND_REVERSE);
	assign s_pop       = s_beat && (s_tuser == KIND_POP_FRONT);
	assign m_removed   = m_tdata[VALUE_W-1:0];
	assign m_beat_bits = {m_tuser, m_tdata};

	// stalled result beat holds
	`DQR_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_beat_bits))

	// a failed op never reports a removed value
	`DQR_ASSERT_NOW(a_fail_zero, clk, arst_n, m_tvalid && !m_tuser[0], m_removed == '0)

	// reverse always succeeds and reports on the next cycle
	`DQR_ASSERT_NEXT(a_rev_ok, clk, arst_n, s_rev, m_tvalid && m_tuser[0] && (m_removed == '0))

	// a pop beat stalls input for the memory read or reports at once
	`DQR_ASSERT_NEXT(a_pop_stall, clk, arst_n, s_pop, !s_tready || m_tvalid)

endmodule

bind double_ended_queue_with_reverse dqr_checker u_dqr_checker (.*);
